>>> sv/c8x_pkg.sv
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared constants, codes and types of the CHIP-8 instruction executor.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int STACK_ENTRIES = 16;
  localparam int DEPTH_W       = $clog2(STACK_ENTRIES + 1);
  localparam int STACK_AW      = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

  localparam logic [11:0] PC_RESET   = 12'h200;
  localparam logic [15:0] INSTR_RET  = 16'h00EE;
  localparam logic [3:0]  REG_0      = 4'h0;
  localparam logic [3:0]  REG_F      = 4'hF;

  // instruction groups, top nibble
  localparam logic [3:0] OP_SYS   = 4'h0;
  localparam logic [3:0] OP_JP    = 4'h1;
  localparam logic [3:0] OP_CALL  = 4'h2;
  localparam logic [3:0] OP_SE_K  = 4'h3;
  localparam logic [3:0] OP_SNE_K = 4'h4;
  localparam logic [3:0] OP_SE_R  = 4'h5;
  localparam logic [3:0] OP_LD_K  = 4'h6;
  localparam logic [3:0] OP_ADD_K = 4'h7;
  localparam logic [3:0] OP_ALU   = 4'h8;
  localparam logic [3:0] OP_SNE_R = 4'h9;
  localparam logic [3:0] OP_LD_I  = 4'hA;
  localparam logic [3:0] OP_JP_V0 = 4'hB;

  // 8xy ALU functions, low nibble
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0]        instr;
    logic [7:0]         vx;
    logic [7:0]         vy;
    logic [7:0]         v0;
    logic [7:0]         vf;
    logic [11:0]        pc;
    logic [11:0]        index;
    logic [DEPTH_W-1:0] depth;
    logic [11:0]        stack_top;
  } exec_in_t;

  typedef struct packed {
    logic [11:0]        pc_next;
    logic [11:0]        index_next;
    logic [DEPTH_W-1:0] depth_next;
    logic               push;
    logic [11:0]        push_data;
    logic               wrote;
    logic [3:0]         wreg;
    logic [7:0]         wdata;
    logic [7:0]         vf_next;
    status_t            status;
  } exec_out_t;

endpackage

>>> sv/c8x_if.sv
// ----------------------------------------------------------------------------
// c8x_in_if / c8x_out_if
// Valid/ready channels for instruction words and execution results.
// ----------------------------------------------------------------------------
interface c8x_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface c8x_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] next_pc;
  logic [11:0] index_value;
  logic        register_written;
  logic [3:0]  written_register;
  logic [7:0]  written_value;
  logic [7:0]  flag_value;
  logic [1:0]  status;

  modport source (output valid, output next_pc, output index_value,
                  output register_written, output written_register,
                  output written_value, output flag_value, output status,
                  input ready);
  modport sink   (input valid, input next_pc, input index_value,
                  input register_written, input written_register,
                  input written_value, input flag_value, input status,
                  output ready);
endinterface

>>> sv/c8x_ram.sv
// ----------------------------------------------------------------------------
// c8x_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/c8x_exec.sv
// ----------------------------------------------------------------------------
// c8x_exec
// Decode and execute of one instruction: ALU, flag, skips, PC, index and stack.
// ----------------------------------------------------------------------------
module c8x_exec (
  input  c8x_pkg::exec_in_t  ex_in,
  output c8x_pkg::exec_out_t ex_out
);
  import c8x_pkg::*;

  logic [3:0]  x;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [11:0] pc_inc;
  logic [7:0]  res;
  logic [7:0]  flag;
  logic        flag_wr;
  logic [8:0]  sum;

  assign x      = ex_in.instr[11:8];
  assign kk     = ex_in.instr[7:0];
  assign nnn    = ex_in.instr[11:0];
  assign pc_inc = ex_in.pc + 12'd2;
  assign sum    = {1'b0, ex_in.vx} + {1'b0, ex_in.vy};

  always_comb begin
    ex_out.pc_next    = pc_inc;
    ex_out.index_next = ex_in.index;
    ex_out.depth_next = ex_in.depth;
    ex_out.push       = 1'b0;
    ex_out.push_data  = pc_inc;
    ex_out.wrote      = 1'b0;
    ex_out.status     = ST_OK;
    res               = '0;
    flag              = '0;
    flag_wr           = 1'b0;

    unique case (ex_in.instr[15:12])
      OP_SYS: begin
        if (ex_in.instr == INSTR_RET) begin
          if (ex_in.depth != '0 && ex_in.depth <= DEPTH_W'(STACK_ENTRIES)) begin
            ex_out.depth_next = ex_in.depth - DEPTH_W'(1);
            ex_out.pc_next    = ex_in.stack_top;
          end else begin
            ex_out.status = ST_UNDERFLOW;
          end
        end
      end
      OP_JP: ex_out.pc_next = nnn;
      OP_CALL: begin
        if (ex_in.depth < DEPTH_W'(STACK_ENTRIES)) begin
          ex_out.push       = 1'b1;
          ex_out.depth_next = ex_in.depth + DEPTH_W'(1);
          ex_out.pc_next    = nnn;
        end else begin
          ex_out.status = ST_OVERFLOW;
        end
      end
      OP_SE_K:  if (ex_in.vx == kk)       ex_out.pc_next = pc_inc + 12'd2;
      OP_SNE_K: if (ex_in.vx != kk)       ex_out.pc_next = pc_inc + 12'd2;
      OP_SE_R:  if (ex_in.vx == ex_in.vy) ex_out.pc_next = pc_inc + 12'd2;
      OP_SNE_R: if (ex_in.vx != ex_in.vy) ex_out.pc_next = pc_inc + 12'd2;
      OP_LD_K: begin
        res          = kk;
        ex_out.wrote = 1'b1;
      end
      OP_ADD_K: begin
        res          = ex_in.vx + kk;
        ex_out.wrote = 1'b1;
      end
      OP_ALU: begin
        ex_out.wrote = 1'b1;
        unique case (ex_in.instr[3:0])
          ALU_MOV: res = ex_in.vy;
          ALU_OR:  res = ex_in.vx | ex_in.vy;
          ALU_AND: res = ex_in.vx & ex_in.vy;
          ALU_XOR: res = ex_in.vx ^ ex_in.vy;
          ALU_ADD: begin
            res     = sum[7:0];
            flag    = {7'd0, sum[8]};
            flag_wr = 1'b1;
          end
          ALU_SUB: begin
            res     = ex_in.vx - ex_in.vy;
            flag    = {7'd0, ex_in.vx > ex_in.vy};
            flag_wr = 1'b1;
          end
          ALU_SHR: begin
            res     = {1'b0, ex_in.vx[7:1]};
            flag    = {7'd0, ex_in.vx[0]};
            flag_wr = 1'b1;
          end
          ALU_SUBN: begin
            res     = ex_in.vy - ex_in.vx;
            flag    = {7'd0, ex_in.vy > ex_in.vx};
            flag_wr = 1'b1;
          end
          ALU_SHL: begin
            res     = {ex_in.vx[6:0], 1'b0};
            flag    = {7'd0, ex_in.vx[7]};
            flag_wr = 1'b1;
          end
          default: begin
            ex_out.wrote  = 1'b0;
            ex_out.status = ST_UNKNOWN;
          end
        endcase
      end
      OP_LD_I:  ex_out.index_next = nnn;
      OP_JP_V0: ex_out.pc_next = nnn + {4'd0, ex_in.v0};
      default:  ex_out.status = ST_UNKNOWN;
    endcase

    // flag first, then Vx: with x = F the ALU result wins
    if (ex_out.wrote && x == REG_F) begin
      ex_out.vf_next = res;
    end else if (flag_wr) begin
      ex_out.vf_next = flag;
    end else begin
      ex_out.vf_next = ex_in.vf;
    end

    ex_out.wreg  = ex_out.wrote ? x : 4'd0;
    ex_out.wdata = ex_out.wrote ? res : 8'd0;
  end

endmodule

>>> sv/chip8_instruction_executor.sv
// ----------------------------------------------------------------------------
// chip8_instruction_executor
// CHIP-8 core: executes one instruction word per item, one item per cycle.
//
//   port    dir  payload                                         item
//   inst    in   instruction[15:0]                               one word
//   result  out  next_pc, index_value, register_written,         one result
//                written_register, written_value, flag_value,
//                status
//
// An item is read from the register file and stack RAMs in its accept cycle
// and executes in the next; one item per cycle while results are taken.
// The PC/stack-depth update loop closes in that execute cycle.
// Reset clears all control state, V0..VE (via per-entry valid bits), VF, I,
// the stack depth, and loads PC with 0x200; no clearing pass is needed.
// A stalled result holds the execute stage, which then holds the input.
// ----------------------------------------------------------------------------
module chip8_instruction_executor (
  input logic       clk,
  input logic       rst,
  c8x_in_if.sink    inst,
  c8x_out_if.source result
);
  import c8x_pkg::*;

  logic               in_fire;
  logic               s1_valid;
  logic [15:0]        s1_instr;
  logic               s1_fwd;
  logic               s1_stk_fwd;
  logic               s1_adv;

  logic [11:0]        pc;
  logic [11:0]        index;
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_eff;
  logic [7:0]         vf;
  logic [7:0]         v0;
  logic [15:0]        reg_valid;

  logic               wb_valid;
  logic [3:0]         wb_addr;
  logic [7:0]         wb_data;
  logic [11:0]        stk_wb_data;

  logic [7:0]         rd_x;
  logic [7:0]         rd_y;
  logic [11:0]        rd_stk;
  logic               ram_we;
  logic [3:0]         sx;
  logic [3:0]         sy;

  logic               out_valid;
  exec_in_t           ex_in;
  exec_out_t          ex_out;

  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign inst.ready = !s1_valid || s1_adv;
  assign in_fire    = inst.valid && inst.ready;
  assign ram_we     = s1_adv && ex_out.wrote && ex_out.wreg != REG_F;
  assign depth_eff  = s1_adv ? ex_out.depth_next : depth;
  assign sx         = s1_instr[11:8];
  assign sy         = s1_instr[7:4];

  // VF lives in a flop, V0 is mirrored in one for Bnnn; V0..VE in RAM,
  // duplicated for the two read ports
  c8x_ram #(.WIDTH(8), .DEPTH(16)) u_regs_x (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ex_out.wreg),
    .wdata (ex_out.wdata),
    .re    (in_fire),
    .raddr (inst.instruction[11:8]),
    .rdata (rd_x)
  );

  c8x_ram #(.WIDTH(8), .DEPTH(16)) u_regs_y (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ex_out.wreg),
    .wdata (ex_out.wdata),
    .re    (in_fire),
    .raddr (inst.instruction[7:4]),
    .rdata (rd_y)
  );

  c8x_ram #(.WIDTH(12), .DEPTH(STACK_ENTRIES)) u_stack (
    .clk   (clk),
    .we    (s1_adv && ex_out.push),
    .waddr (STACK_AW'(depth)),
    .wdata (ex_out.push_data),
    .re    (in_fire),
    .raddr (STACK_AW'(depth_eff - DEPTH_W'(1))),
    .rdata (rd_stk)
  );

  // operand select: VF flop, then the write that landed on the read edge, then RAM or zero
  always_comb begin
    ex_in.instr = s1_instr;
    ex_in.v0    = v0;
    ex_in.vf    = vf;
    ex_in.pc    = pc;
    ex_in.index = index;
    ex_in.depth = depth;

    if (sx == REG_F) begin
      ex_in.vx = vf;
    end else if (s1_fwd && wb_valid && wb_addr == sx) begin
      ex_in.vx = wb_data;
    end else if (reg_valid[sx]) begin
      ex_in.vx = rd_x;
    end else begin
      ex_in.vx = '0;
    end

    if (sy == REG_F) begin
      ex_in.vy = vf;
    end else if (s1_fwd && wb_valid && wb_addr == sy) begin
      ex_in.vy = wb_data;
    end else if (reg_valid[sy]) begin
      ex_in.vy = rd_y;
    end else begin
      ex_in.vy = '0;
    end

    ex_in.stack_top = s1_stk_fwd ? stk_wb_data : rd_stk;
  end

  c8x_exec u_exec (
    .ex_in  (ex_in),
    .ex_out (ex_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s1_fwd     <= 1'b0;
      s1_stk_fwd <= 1'b0;
      out_valid  <= 1'b0;
      pc         <= PC_RESET;
      index      <= '0;
      depth      <= '0;
      vf         <= '0;
      v0         <= '0;
      reg_valid  <= '0;
      wb_valid   <= 1'b0;
    end else begin
      if (inst.ready) begin
        s1_valid <= inst.valid;
      end
      if (in_fire) begin
        s1_instr   <= inst.instruction;
        s1_fwd     <= s1_adv;
        s1_stk_fwd <= s1_adv && ex_out.push;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (s1_adv) begin
        pc       <= ex_out.pc_next;
        index    <= ex_out.index_next;
        depth    <= ex_out.depth_next;
        vf       <= ex_out.vf_next;
        wb_valid <= ram_we;
        if (ram_we) begin
          reg_valid[ex_out.wreg] <= 1'b1;
        end
        if (ex_out.wrote && ex_out.wreg == REG_0) begin
          v0 <= ex_out.wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      wb_addr                 <= ex_out.wreg;
      wb_data                 <= ex_out.wdata;
      result.next_pc          <= ex_out.pc_next;
      result.index_value      <= ex_out.index_next;
      result.register_written <= ex_out.wrote;
      result.written_register <= ex_out.wreg;
      result.written_value    <= ex_out.wdata;
      result.flag_value       <= ex_out.vf_next;
      result.status           <= ex_out.status;
      if (ex_out.push) begin
        stk_wb_data <= ex_out.push_data;
      end
    end
  end

  assign result.valid = out_valid;

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    s1_adv && ex_out.push |-> depth < DEPTH_W'(STACK_ENTRIES))
    else $error("push with full return stack");

  a_push_depth: assert property (@(posedge clk) disable iff (rst)
    s1_adv && ex_out.push |=> depth == $past(depth) + DEPTH_W'(1))
    else $error("stack depth did not advance on push");

  a_reset_pc: assert property (@(posedge clk)
    rst |=> pc == PC_RESET)
    else $error("PC not at reset vector after reset");

  a_no_ram_vf: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ex_out.wreg != REG_F && ex_out.wrote)
    else $error("register RAM written for VF or without a write");

  a_overflow_pc: assert property (@(posedge clk) disable iff (rst)
    s1_adv && ex_out.status == ST_OVERFLOW |-> ex_out.pc_next == pc + 12'd2)
    else $error("overflowing call changed control flow");

endmodule
